/* hw/rtl/nfsa_pkg.sv */
`default_nettype none

package nfsa_pkg;

   // Operation codes carried in the opcode field.
   localparam logic [1:0] OP_ALLOC_ANY = 2'd0;
   localparam logic [1:0] OP_ALLOC_ID  = 2'd1;
   localparam logic [1:0] OP_RELEASE   = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_RANGE  = 3'd2;
   localparam logic [2:0] ST_TAKEN  = 3'd3;
   localparam logic [2:0] ST_FREE   = 3'd4;

   // Configuration port layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ACTIVE_SLOTS = 1'b0;

   // Slot counts and identifiers.
   localparam int SLOT_ID_W  = 8;
   localparam int COUNT_W    = 9;
   localparam int MAX_SLOTS  = 256;
   localparam logic [COUNT_W-1:0] ACTIVE_RESET = 9'd256;

   // The search examines one group of this many slots per cycle.
   localparam int CHUNK_W   = 16;
   localparam int CHUNK_LOG = 4;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [SLOT_ID_W-1:0] slot_id;
   } req_word_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [SLOT_ID_W-1:0] granted_slot;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic load_live;
      logic park;
      logic load_held;
   } ctl_cmd_type;

   typedef struct packed {
      logic step_done;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

/* hw/rtl/nfsa_ctrl.sv */
`default_nettype none

module nfsa_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  nfsa_pkg::dp_stat_type stat,
   output nfsa_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.step = 1'b1;
            if (stat.step_done) begin
               if (stat.out_free) begin
                  cmd.load_live = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.park = 1'b1;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (stat.out_free) begin
               cmd.load_held = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/nfsa_datapath.sv */
`default_nettype none

module nfsa_datapath #(
   parameter int SLOTS = 256
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  nfsa_pkg::ctl_cmd_type                     cmd,
   output nfsa_pkg::dp_stat_type                     stat,
   input  nfsa_pkg::req_word_type                    req_word,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output nfsa_pkg::rsp_word_type                    rsp_word,
   input  wire                                       csr_psel,
   input  wire                                       csr_penable,
   input  wire                                       csr_pwrite,
   input  wire  [nfsa_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  wire  [nfsa_pkg::CSR_DATA_W-1:0]           csr_pwdata,
   output logic [nfsa_pkg::CSR_DATA_W-1:0]           csr_prdata
);

   // Slot IDs are eight bits wide, so no more than 256 slots are ever reachable.
   localparam int MAP_DEPTH = (SLOTS < nfsa_pkg::MAX_SLOTS) ? SLOTS : nfsa_pkg::MAX_SLOTS;
   localparam int IDX_W     = $clog2(MAP_DEPTH);
   localparam int CHUNKS    = (MAP_DEPTH + nfsa_pkg::CHUNK_W - 1) / nfsa_pkg::CHUNK_W;
   localparam int CH_W      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam logic [nfsa_pkg::COUNT_W-1:0] MAP_N = nfsa_pkg::COUNT_W'(MAP_DEPTH);

   logic [MAP_DEPTH-1:0]              occ_ff, occ_in;
   logic [nfsa_pkg::SLOT_ID_W-1:0]    ptr_ff, ptr_in;
   logic [nfsa_pkg::COUNT_W-1:0]      act_ff, act_in;
   logic [1:0]                        op_ff;
   logic [nfsa_pkg::SLOT_ID_W-1:0]    id_ff;
   logic [nfsa_pkg::SLOT_ID_W-1:0]    start_ff, start_in;
   logic [CH_W-1:0]                   chunk_ff, chunk_in;
   logic                              phase_ff, phase_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   nfsa_pkg::rsp_word_type            rsp_word_ff, held_ff, live_word;

   logic [nfsa_pkg::CHUNK_W-1:0]      occ_chunks [CHUNKS];
   logic [nfsa_pkg::COUNT_W-1:0]      n_eff;
   logic [nfsa_pkg::COUNT_W-1:0]      start_sh, last_sh, base9, slot9, id9, next9;
   logic [CH_W-1:0]                   first_chunk, last_chunk;
   logic [nfsa_pkg::CHUNK_W-1:0]      cand;
   logic [nfsa_pkg::CHUNK_LOG-1:0]    pos;
   logic                              hit;
   logic                              done;
   logic                              map_wr, map_val;
   logic [IDX_W-1:0]                  map_idx;
   logic                              take_ptr;
   logic                              csr_wr;

   // Slots past the end of the map read as occupied so the search never grants them.
   for (genvar i = 0; i < CHUNKS * nfsa_pkg::CHUNK_W; i++) begin : g_pad
      if (i < MAP_DEPTH) begin : g_real
         assign occ_chunks[i / nfsa_pkg::CHUNK_W][i % nfsa_pkg::CHUNK_W] = occ_ff[i];
      end else begin : g_fill
         assign occ_chunks[i / nfsa_pkg::CHUNK_W][i % nfsa_pkg::CHUNK_W] = 1'b1;
      end
   end

   assign n_eff = (act_ff > MAP_N) ? MAP_N : act_ff;

   // Start point of the next-fit search, fixed when the word is accepted.
   assign start_in = ({1'b0, ptr_ff} < n_eff) ? ptr_ff : '0;

   assign start_sh    = {1'b0, start_ff} >> nfsa_pkg::CHUNK_LOG;
   assign last_sh     = (n_eff - 9'd1) >> nfsa_pkg::CHUNK_LOG;
   assign first_chunk = start_sh[CH_W-1:0];
   assign last_chunk  = last_sh[CH_W-1:0];
   assign base9       = nfsa_pkg::COUNT_W'(chunk_ff) << nfsa_pkg::CHUNK_LOG;
   assign id9         = {1'b0, id_ff};

   // Before the wrap the search covers slots from the start point up to the
   // active count; after the wrap it covers slots below the start point.
   always_comb begin
      logic [nfsa_pkg::COUNT_W-1:0] idx;
      for (int b = 0; b < nfsa_pkg::CHUNK_W; b++) begin
         idx = base9 + nfsa_pkg::COUNT_W'(b);
         if (phase_ff) begin
            cand[b] = ~occ_chunks[chunk_ff][b] & (idx < {1'b0, start_ff});
         end else begin
            cand[b] = ~occ_chunks[chunk_ff][b] & (idx >= {1'b0, start_ff}) & (idx < n_eff);
         end
      end
   end

   always_comb begin
      pos = '0;
      for (int b = nfsa_pkg::CHUNK_W - 1; b >= 0; b--) begin
         if (cand[b]) begin
            pos = nfsa_pkg::CHUNK_LOG'(b);
         end
      end
   end

   assign hit   = |cand;
   assign slot9 = base9 | nfsa_pkg::COUNT_W'(pos);

   // One step of the current operation: result, map write and pointer move.
   always_comb begin
      done                   = 1'b1;
      live_word.status       = nfsa_pkg::ST_RANGE;
      live_word.granted_slot = '0;
      map_wr                 = 1'b0;
      map_val                = 1'b0;
      map_idx                = id_ff[IDX_W-1:0];
      take_ptr               = 1'b0;
      next9                  = id9 + 9'd1;
      chunk_in               = chunk_ff;
      phase_in               = phase_ff;
      case (op_ff)
         nfsa_pkg::OP_ALLOC_ANY: begin
            next9 = slot9 + 9'd1;
            if (n_eff == '0) begin
               live_word.status = nfsa_pkg::ST_FULL;
            end else if (hit) begin
               live_word.status       = nfsa_pkg::ST_OK;
               live_word.granted_slot = slot9[nfsa_pkg::SLOT_ID_W-1:0];
               map_wr                 = 1'b1;
               map_val                = 1'b1;
               map_idx                = slot9[IDX_W-1:0];
               take_ptr               = 1'b1;
            end else if (phase_ff && (chunk_ff == first_chunk)) begin
               live_word.status = nfsa_pkg::ST_FULL;
            end else begin
               done = 1'b0;
               if (!phase_ff && (chunk_ff == last_chunk)) begin
                  phase_in = 1'b1;
                  chunk_in = '0;
               end else begin
                  chunk_in = chunk_ff + 1'b1;
               end
            end
         end
         nfsa_pkg::OP_ALLOC_ID: begin
            if (id9 >= n_eff) begin
               live_word.status = nfsa_pkg::ST_RANGE;
            end else if (occ_ff[id_ff[IDX_W-1:0]]) begin
               live_word.status = nfsa_pkg::ST_TAKEN;
            end else begin
               live_word.status       = nfsa_pkg::ST_OK;
               live_word.granted_slot = id_ff;
               map_wr                 = 1'b1;
               map_val                = 1'b1;
               take_ptr               = 1'b1;
            end
         end
         nfsa_pkg::OP_RELEASE: begin
            if (id9 >= n_eff) begin
               live_word.status = nfsa_pkg::ST_RANGE;
            end else if (!occ_ff[id_ff[IDX_W-1:0]]) begin
               live_word.status = nfsa_pkg::ST_FREE;
            end else begin
               live_word.status = nfsa_pkg::ST_OK;
               map_wr           = 1'b1;
               map_val          = 1'b0;
            end
         end
         default: begin
            live_word.status = nfsa_pkg::ST_RANGE;
         end
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      ptr_in = ptr_ff;
      if (cmd.step && done && map_wr) begin
         occ_in[map_idx] = map_val;
      end
      if (cmd.step && done && take_ptr) begin
         ptr_in = (next9 >= n_eff) ? '0 : next9[nfsa_pkg::SLOT_ID_W-1:0];
      end
   end

   assign stat.step_done = done;
   assign stat.out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Output register: a finished word waits here while the next one is accepted.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.load_live || cmd.load_held) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign csr_wr = csr_psel & csr_penable & csr_pwrite &
                   (csr_paddr[2] == nfsa_pkg::REG_ACTIVE_SLOTS);
   assign act_in = csr_wr ? csr_pwdata[nfsa_pkg::COUNT_W-1:0] : act_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == nfsa_pkg::REG_ACTIVE_SLOTS) begin
         csr_prdata = nfsa_pkg::CSR_DATA_W'(act_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         ptr_ff       <= '0;
         act_ff       <= nfsa_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         ptr_ff       <= ptr_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_word.opcode;
         id_ff    <= req_word.slot_id;
         start_ff <= start_in;
         chunk_ff <= CH_W'({1'b0, start_in} >> nfsa_pkg::CHUNK_LOG);
         phase_ff <= 1'b0;
      end else if (cmd.step) begin
         chunk_ff <= chunk_in;
         phase_ff <= phase_in;
      end
      if (cmd.park) begin
         held_ff <= live_word;
      end
      if (cmd.load_live) begin
         rsp_word_ff <= live_word;
      end else if (cmd.load_held) begin
         rsp_word_ff <= held_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* hw/rtl/next_fit_slot_allocator.sv */
// A result word is loaded into the output register after the single step of a named
// allocate or release, or after an allocate-any scan, one group of 16 slots per cycle.
// A new word is accepted only from idle, once the last result has left the scan or hold;
// allocate-any steps once per group the next-fit scan visits, using the single scanner.
// Reset (synchronous): all slots free, search pointer zero, active_slots 256.
// The occupied map is flip-flops cleared at once, so no clearing pass follows reset.
`default_nettype none

module next_fit_slot_allocator #(
   parameter int SLOTS = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  nfsa_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output nfsa_pkg::rsp_word_type              rsp_word,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [nfsa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [nfsa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nfsa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   nfsa_pkg::ctl_cmd_type cmd;
   nfsa_pkg::dp_stat_type stat;

   assign csr_pready = 1'b1;

   nfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nfsa_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

`default_nettype wire

/* verif/next_fit_slot_allocator_tb.sv */
`default_nettype none

module next_fit_slot_allocator_tb;
   import nfsa_pkg::*;

   localparam int TB_SLOTS      = 256;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 220;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ACTIVE_SLOTS_ADDR = CSR_ADDR_W'(4 * REG_ACTIVE_SLOTS);

   // Tracks the occupied map and search pointer of the allocator and holds the
   // result words still owed by the block, oldest first.
   class slot_grant_board;
      bit                   occupied [MAX_SLOTS];
      logic [SLOT_ID_W-1:0] pointer;
      logic [COUNT_W-1:0]   active;
      rsp_word_type         grants_due [$];
      int                   mismatches;

      function new();
         foreach (occupied[i]) occupied[i] = 1'b0;
         pointer    = '0;
         active     = ACTIVE_RESET;
         mismatches = 0;
      endfunction

      function void set_active(logic [COUNT_W-1:0] value);
         active = value;
      endfunction

      function int slots_in_force();
         int n;
         n = active;
         if (n > TB_SLOTS) n = TB_SLOTS;
         if (n > MAX_SLOTS) n = MAX_SLOTS;
         return n;
      endfunction

      function int occupied_count();
         int total;
         total = 0;
         for (int i = 0; i < slots_in_force(); i++) total += occupied[i];
         return total;
      endfunction

      // Returns some occupied slot in range, or a random one if none is taken.
      function int pick_occupied();
         int n, start, s;
         n     = slots_in_force();
         start = $urandom_range(0, n - 1);
         for (int i = 0; i < n; i++) begin
            s = (start + i) % n;
            if (occupied[s]) return s;
         end
         return start;
      endfunction

      function void take_slot(int s, int n);
         int after;
         occupied[s] = 1'b1;
         after = s + 1;
         if (after >= n) after = 0;
         pointer = after[SLOT_ID_W-1:0];
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type res;
         int           n, start, s, id;
         bit           found;
         n     = slots_in_force();
         id    = w.slot_id;
         found = 1'b0;
         res.status       = ST_RANGE;
         res.granted_slot = '0;
         case (w.opcode)
            OP_ALLOC_ANY: begin
               res.status = ST_FULL;
               start = pointer;
               if (start >= n) start = 0;
               for (int i = 0; i < n && !found; i++) begin
                  s = start + i;
                  if (s >= n) s -= n;
                  if (!occupied[s]) begin
                     take_slot(s, n);
                     res.status       = ST_OK;
                     res.granted_slot = s[SLOT_ID_W-1:0];
                     found            = 1'b1;
                  end
               end
            end
            OP_ALLOC_ID: begin
               if (id >= n) begin
                  res.status = ST_RANGE;
               end else if (occupied[id]) begin
                  res.status = ST_TAKEN;
               end else begin
                  take_slot(id, n);
                  res.status       = ST_OK;
                  res.granted_slot = w.slot_id;
               end
            end
            OP_RELEASE: begin
               if (id >= n) begin
                  res.status = ST_RANGE;
               end else if (!occupied[id]) begin
                  res.status = ST_FREE;
               end else begin
                  occupied[id] = 1'b0;
                  res.status   = ST_OK;
               end
            end
            default: res.status = ST_RANGE;
         endcase
         grants_due.push_back(res);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
      endfunction

      function void check_grant(rsp_word_type got);
         rsp_word_type want;
         if (grants_due.size() == 0) begin
            report($sformatf("result word with none pending: status %0d slot %0d",
                             got.status, got.granted_slot));
            return;
         end
         want = grants_due.pop_front();
         if (got.status !== want.status)
            report($sformatf("status expected %0d, got %0d", want.status, got.status));
         if (got.granted_slot !== want.granted_slot)
            report($sformatf("granted_slot expected %0d, got %0d",
                             want.granted_slot, got.granted_slot));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycles = 0;

   slot_grant_board sb = new();

   next_fit_slot_allocator #(.SLOTS(TB_SLOTS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_word);
         if (rsp_valid && !rsp_stall) sb.check_grant(rsp_word);
      end
   end

   // Result side: a requested long hold-off takes priority over random stalls.
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic req_word_type mk(logic [1:0] op, logic [SLOT_ID_W-1:0] id);
      req_word_type w;
      w.opcode  = op;
      w.slot_id = id;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // A word accepted at the current edge is noted by the monitor in this same
   // time step, so the count is only trusted from the next edge on.
   task automatic wait_drained();
      @(posedge clock);
      while (sb.grants_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= ACTIVE_SLOTS_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // The register is only touched once the block has answered every word.
   task automatic set_active_slots(input int value);
      logic [CSR_DATA_W-1:0] rdata;
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, CSR_DATA_W'(value), rdata);
      sb.set_active(COUNT_W'(value));
      csr_access(1'b0, '0, rdata);
      if (rdata !== CSR_DATA_W'(value))
         sb.report($sformatf("active_slots read back %0d, expected %0d", rdata, value));
   endtask

   function automatic req_word_type pick_word(bit filling);
      req_word_type w;
      int           n, r;
      n = sb.slots_in_force();
      r = $urandom_range(0, 99);
      w.slot_id = SLOT_ID_W'($urandom_range(0, 255));
      if (r < 6) begin
         w.opcode = 2'($urandom_range(0, 3));
      end else if (filling) begin
         if (r < 60) begin
            w.opcode = OP_ALLOC_ANY;
         end else if (r < 75) begin
            w.opcode  = OP_ALLOC_ID;
            w.slot_id = SLOT_ID_W'($urandom_range(0, n - 1));
         end else if (r < 85) begin
            w.opcode  = OP_RELEASE;
            w.slot_id = SLOT_ID_W'(sb.pick_occupied());
         end else begin
            w.opcode  = OP_RELEASE;
            w.slot_id = SLOT_ID_W'($urandom_range(0, n - 1));
         end
      end else begin
         if (r < 60) begin
            w.opcode  = OP_RELEASE;
            w.slot_id = SLOT_ID_W'(sb.pick_occupied());
         end else if (r < 72) begin
            w.opcode  = OP_RELEASE;
            w.slot_id = SLOT_ID_W'($urandom_range(0, n - 1));
         end else if (r < 86) begin
            w.opcode = OP_ALLOC_ANY;
         end else begin
            w.opcode  = OP_ALLOC_ID;
            w.slot_id = SLOT_ID_W'($urandom_range(0, n - 1));
         end
      end
      return w;
   endfunction

   // Fill the pool, switching at random once every slot is taken, then drain it to an eighth, and repeat.
   task automatic run_random(input int count, input int slots, input bit with_hold);
      bit filling;
      int n;
      filling = 1'b1;
      set_active_slots(slots);
      if (with_hold) hold_asks <= hold_asks + 1;
      n = sb.slots_in_force();
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         if (filling && sb.occupied_count() == n && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if (!filling && sb.occupied_count() <= n / 8)
            filling = 1'b1;
         send_word(pick_word(filling));
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   initial begin
      set_idling(9, 68);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full pool of 256: next-fit order, wrap of the pointer after the top slot,
      // taken and already-free cases, and the unused opcode.
      send_word(mk(OP_ALLOC_ANY, 8'd0));
      send_word(mk(OP_ALLOC_ANY, 8'd0));
      send_word(mk(OP_ALLOC_ANY, 8'd0));
      send_word(mk(OP_ALLOC_ID, 8'd255));
      send_word(mk(OP_ALLOC_ANY, 8'd0));
      send_word(mk(OP_ALLOC_ID, 8'd1));
      send_word(mk(OP_RELEASE, 8'd255));
      send_word(mk(OP_RELEASE, 8'd255));
      send_word(mk(OP_RELEASE, 8'd0));
      send_word(mk(OP_ALLOC_ANY, 8'd255));
      send_word(mk(OP_UNUSED, 8'd255));
      send_word(mk(OP_UNUSED, 8'd0));
      send_word(mk(OP_ALLOC_ID, 8'd0));

      // A single active slot: the pointer now lies beyond the pool, slots
      // above the pool are out of range, and a second request finds it full.
      set_active_slots(1);
      send_word(mk(OP_RELEASE, 8'd0));
      send_word(mk(OP_ALLOC_ANY, 8'd0));
      send_word(mk(OP_ALLOC_ANY, 8'd0));
      send_word(mk(OP_ALLOC_ID, 8'd0));
      send_word(mk(OP_ALLOC_ID, 8'd1));
      send_word(mk(OP_RELEASE, 8'd1));
      send_word(mk(OP_RELEASE, 8'd0));
      send_word(mk(OP_RELEASE, 8'd0));
      send_word(mk(OP_ALLOC_ID, 8'd255));

      run_random(330, 256, 1'b1);
      run_random(100, 16, 1'b0);
      set_idling(68, 9);
      run_random(150, 17, 1'b0);
      run_random(60, 1, 1'b0);
      set_idling(0, 0);
      run_random(200, 255, 1'b1);
      run_random(110, 100, 1'b0);

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.grants_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
